[rtl/core/scpa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the size class pool allocator.
// No dependencies; every file but scpa_ram imports this package.
package scpa_pkg;

	localparam int SMALL_SLOTS  = 1024;
	localparam int MEDIUM_SLOTS = 256;
	localparam int LARGE_SLOTS  = 64;
	localparam int TOTAL_SLOTS  = SMALL_SLOTS + MEDIUM_SLOTS + LARGE_SLOTS;
	localparam int ADDR_W       = $clog2(TOTAL_SLOTS);

	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 11;
	localparam int BYTES_W = 40;
	localparam int GRANT_W = 32;
	localparam int REQ_W   = 32;
	localparam int SIZE_W  = 16;
	localparam int HDR_W   = 6;

	localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
	localparam logic [GRANT_W-1:0] GRANT_MAX = {GRANT_W{1'b1}};

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		CLS_SMALL  = 2'd0,
		CLS_MEDIUM = 2'd1,
		CLS_LARGE  = 2'd2,
		CLS_SYSTEM = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		ST_POOL_ALLOC = 2'd0,
		ST_FALLBACK   = 2'd1,
		ST_FREED      = 2'd2,
		ST_REJECTED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_HEADER = 2'd0,
		CFG_SMALL  = 2'd1,
		CFG_MEDIUM = 2'd2,
		CFG_LARGE  = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_CALC = 2'd1,
		FSM_EXEC = 2'd2
	} fsm_state_t;

	// One slot's memory word: free list link, allocated flag, request size.
	typedef struct packed {
		logic [SLOT_W-1:0] link;
		logic              allocated;
		logic [SIZE_W-1:0] bytes;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	typedef struct packed {
		logic               commit;
		logic               add;
		logic               sub;
		logic               count;
		class_t             count_cls;
		logic [REQ_W-1:0]   amount;
	} stat_cmd_t;

	function automatic logic [COUNT_W-1:0] class_slots(input logic [1:0] c);
		logic [COUNT_W-1:0] n;
		case (c)
			CLS_SMALL:  n = COUNT_W'(SMALL_SLOTS);
			CLS_MEDIUM: n = COUNT_W'(MEDIUM_SLOTS);
			default:    n = COUNT_W'(LARGE_SLOTS);
		endcase
		return n;
	endfunction

	function automatic logic [ADDR_W-1:0] class_base(input logic [1:0] c);
		logic [ADDR_W-1:0] b;
		case (c)
			CLS_SMALL:  b = '0;
			CLS_MEDIUM: b = ADDR_W'(SMALL_SLOTS);
			default:    b = ADDR_W'(SMALL_SLOTS + MEDIUM_SLOTS);
		endcase
		return b;
	endfunction

endpackage

[rtl/core/scpa_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on scpa_pkg for field widths.
interface scpa_req_if import scpa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [REQ_W-1:0]   request_bytes;
	logic [1:0]         free_class;
	logic [SLOT_W-1:0]  free_slot;

	modport source (output valid, opcode, request_bytes, free_class, free_slot, input ready);
	modport sink (input valid, opcode, request_bytes, free_class, free_slot, output ready);
endinterface

interface scpa_rsp_if import scpa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [1:0]         granted_class;
	logic [SLOT_W-1:0]  granted_slot;
	logic [COUNT_W-1:0] class_in_use;
	logic [BYTES_W-1:0] current_bytes;
	logic [BYTES_W-1:0] peak_bytes;

	modport source (output valid, status, granted_class, granted_slot, class_in_use,
		current_bytes, peak_bytes, input ready);
	modport sink (input valid, status, granted_class, granted_slot, class_in_use,
		current_bytes, peak_bytes, output ready);
endinterface

[rtl/core/scpa_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/core/scpa_stats.sv]
`timescale 1ns / 1ps
// Saturating byte counters and per-class grant counters.
// Depends on scpa_pkg for stat_cmd_t and widths.
module scpa_stats import scpa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  stat_cmd_t          cmd,
	output logic [BYTES_W-1:0] cur_nxt,
	output logic [BYTES_W-1:0] peak_nxt
);
	logic [BYTES_W-1:0] cur_q, peak_q, tot_alloc_q, tot_free_q;
	logic [GRANT_W-1:0] grant_q [4];
	logic [BYTES_W:0]   cur_sum, alloc_sum, free_sum;
	logic [BYTES_W-1:0] amt, alloc_nxt, free_nxt;

	assign amt       = BYTES_W'(cmd.amount);
	assign cur_sum   = {1'b0, cur_q} + {1'b0, amt};
	assign alloc_sum = {1'b0, tot_alloc_q} + {1'b0, amt};
	assign free_sum  = {1'b0, tot_free_q} + {1'b0, amt};

	always_comb begin
		cur_nxt   = cur_q;
		alloc_nxt = tot_alloc_q;
		free_nxt  = tot_free_q;
		if (cmd.add) begin
			cur_nxt   = cur_sum[BYTES_W] ? BYTES_MAX : cur_sum[BYTES_W-1:0];
			alloc_nxt = alloc_sum[BYTES_W] ? BYTES_MAX : alloc_sum[BYTES_W-1:0];
		end else if (cmd.sub) begin
			cur_nxt  = (cur_q > amt) ? cur_q - amt : '0;
			free_nxt = free_sum[BYTES_W] ? BYTES_MAX : free_sum[BYTES_W-1:0];
		end
		peak_nxt = (cur_nxt > peak_q) ? cur_nxt : peak_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			peak_q      <= '0;
			tot_alloc_q <= '0;
			tot_free_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				grant_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			cur_q       <= cur_nxt;
			peak_q      <= peak_nxt;
			tot_alloc_q <= alloc_nxt;
			tot_free_q  <= free_nxt;
			if (cmd.count && grant_q[cmd.count_cls] != GRANT_MAX) begin
				grant_q[cmd.count_cls] <= grant_q[cmd.count_cls] + 1'b1;
			end
		end
	end
endmodule

[rtl/core/size_class_pool_allocator_top.sv]
`timescale 1ns / 1ps
// Size class pool allocator: three LIFO slot pools plus system fallback.
// A request is taken in IDLE, its slot word is read in CALC and it commits in EXEC.
// EXEC waits while the result is unread; no new request is taken until it commits.
// Reset: lists come up full without a clearing pass; a per-class watermark stands in
// for never-touched slots. Counters clear; config registers take their default values.
module size_class_pool_allocator_top import scpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [SIZE_W-1:0]    cfg_wdata,
	scpa_req_if.sink             req,
	scpa_rsp_if.source           rsp
);
	// Configuration.
	logic [HDR_W-1:0]  header_q;
	logic [SIZE_W-1:0] small_q, medium_q, large_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HDR_W'(40);
			small_q  <= SIZE_W'(64);
			medium_q <= SIZE_W'(256);
			large_q  <= SIZE_W'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER: header_q <= cfg_wdata[HDR_W-1:0];
				CFG_SMALL:  small_q  <= cfg_wdata;
				CFG_MEDIUM: medium_q <= cfg_wdata;
				CFG_LARGE:  large_q  <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	fsm_state_t state_q, state_nxt;
	logic out_free, commit, ram_re, ram_we;

	// Request registers.
	logic              opcode_q;
	logic [REQ_W-1:0]  req_bytes_q;
	logic [1:0]        fcls_q;
	logic [SLOT_W-1:0] fslot_q;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_q    <= req.opcode;
			req_bytes_q <= req.request_bytes;
			fcls_q      <= req.free_class;
			fslot_q     <= req.free_slot;
		end
	end

	// Per-class list state.
	logic [SLOT_W-1:0]  heads_q [3];
	logic [COUNT_W-1:0] in_use_q [3];
	logic [COUNT_W-1:0] wmark_q [3];

	// Class selection in CALC.
	logic [REQ_W:0]    need;
	logic [1:0]        fit_cls;
	logic              fit_pool;
	logic [ADDR_W-1:0] raddr;
	logic [1:0]        cls_s2;
	logic              pool_s2;

	assign need = {1'b0, req_bytes_q} + (REQ_W+1)'(header_q);

	always_comb begin
		if (need <= (REQ_W+1)'(small_q)) begin
			fit_cls = CLS_SMALL;
		end else if (need <= (REQ_W+1)'(medium_q)) begin
			fit_cls = CLS_MEDIUM;
		end else if (need <= (REQ_W+1)'(large_q)) begin
			fit_cls = CLS_LARGE;
		end else begin
			fit_cls = CLS_SYSTEM;
		end
		fit_pool = (fit_cls != CLS_SYSTEM) &&
			(in_use_q[fit_cls[1] ? 2 : fit_cls[0] ? 1 : 0] < class_slots(fit_cls));
		if (opcode_q == OP_ALLOC) begin
			raddr = class_base(fit_cls)
				+ ADDR_W'(heads_q[fit_cls[1] ? 2 : fit_cls[0] ? 1 : 0]);
		end else begin
			raddr = class_base(fcls_q) + ADDR_W'(fslot_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FSM_CALC) begin
			cls_s2  <= (opcode_q == OP_ALLOC) ? (fit_pool ? fit_cls : CLS_SYSTEM) : fcls_q;
			pool_s2 <= (opcode_q == OP_ALLOC) ? fit_pool : (fcls_q != CLS_SYSTEM);
		end
	end

	// Slot memory: link, allocated flag and size of every slot of every class.
	slot_entry_t       rd_entry, wr_entry;
	logic [ADDR_W-1:0] waddr;

	scpa_ram #(.WIDTH(ENTRY_W), .DEPTH(TOTAL_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	// Execution in EXEC.
	logic [1:0]         ci;
	logic [SLOT_W-1:0]  head;
	logic [COUNT_W-1:0] in_use, wmark;
	logic               head_fresh, free_ok;
	logic [SLOT_W-1:0]  next_head;
	stat_cmd_t          scmd;
	logic [BYTES_W-1:0] cur_nxt, peak_nxt;
	logic [1:0]         o_status, o_cls;
	logic [SLOT_W-1:0]  o_slot;
	logic [COUNT_W-1:0] o_inuse;

	assign ci     = cls_s2[1] ? 2'd2 : cls_s2;
	assign head   = heads_q[ci];
	assign in_use = in_use_q[ci];
	assign wmark  = wmark_q[ci];
	// Slots below the watermark were never handed out, so their memory word is stale.
	assign head_fresh = COUNT_W'(head) < wmark;
	assign next_head  = head_fresh ? ((head == '0) ? '0 : head - 1'b1) : rd_entry.link;
	assign free_ok    = (COUNT_W'(fslot_q) < class_slots(cls_s2))
		&& (COUNT_W'(fslot_q) >= wmark) && rd_entry.allocated;

	always_comb begin
		scmd           = '0;
		scmd.commit    = commit;
		ram_we         = 1'b0;
		waddr          = class_base(cls_s2) + ADDR_W'(head);
		wr_entry       = rd_entry;
		o_status       = ST_FALLBACK;
		o_cls          = CLS_SYSTEM;
		o_slot         = '0;
		o_inuse        = '0;
		if (opcode_q == OP_ALLOC) begin
			scmd.add    = 1'b1;
			scmd.count  = 1'b1;
			scmd.amount = req_bytes_q;
			if (pool_s2) begin
				scmd.count_cls     = class_t'(cls_s2);
				ram_we             = commit;
				wr_entry.allocated = 1'b1;
				wr_entry.bytes     = req_bytes_q[SIZE_W-1:0];
				o_status           = ST_POOL_ALLOC;
				o_cls              = cls_s2;
				o_slot             = head;
				o_inuse            = in_use + 1'b1;
			end else begin
				scmd.count_cls = CLS_SYSTEM;
			end
		end else if (!pool_s2) begin
			scmd.sub    = 1'b1;
			scmd.amount = req_bytes_q;
			o_status    = ST_FREED;
		end else begin
			o_cls   = cls_s2;
			o_slot  = fslot_q;
			o_inuse = in_use;
			waddr   = class_base(cls_s2) + ADDR_W'(fslot_q);
			if (free_ok) begin
				scmd.sub           = 1'b1;
				scmd.amount        = REQ_W'(rd_entry.bytes);
				ram_we             = commit;
				wr_entry.link      = head;
				wr_entry.allocated = 1'b0;
				o_status           = ST_FREED;
				o_inuse            = in_use - 1'b1;
			end else begin
				o_status = ST_REJECTED;
			end
		end
	end

	scpa_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (scmd),
		.cur_nxt  (cur_nxt),
		.peak_nxt (peak_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				heads_q[i]  <= SLOT_W'(class_slots(2'(i)) - 1'b1);
				in_use_q[i] <= '0;
				wmark_q[i]  <= class_slots(2'(i));
			end
		end else if (commit && pool_s2) begin
			if (opcode_q == OP_ALLOC) begin
				heads_q[ci]  <= next_head;
				in_use_q[ci] <= in_use + 1'b1;
				if (head_fresh) begin
					wmark_q[ci] <= COUNT_W'(head);
				end
			end else if (free_ok) begin
				heads_q[ci]  <= fslot_q;
				in_use_q[ci] <= in_use - 1'b1;
			end
		end
	end

	// Output register.
	logic               out_valid_q;
	logic [1:0]         status_q, gcls_q;
	logic [SLOT_W-1:0]  gslot_q;
	logic [COUNT_W-1:0] inuse_q;
	logic [BYTES_W-1:0] cur_q, peak_q;

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= o_status;
			gcls_q   <= o_cls;
			gslot_q  <= o_slot;
			inuse_q  <= o_inuse;
			cur_q    <= cur_nxt;
			peak_q   <= peak_nxt;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_class = gcls_q;
	assign rsp.granted_slot  = gslot_q;
	assign rsp.class_in_use  = inuse_q;
	assign rsp.current_bytes = cur_q;
	assign rsp.peak_bytes    = peak_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		case (state_q)
			FSM_IDLE: state_nxt = req.valid ? FSM_CALC : FSM_IDLE;
			FSM_CALC: state_nxt = FSM_EXEC;
			FSM_EXEC: state_nxt = out_free ? FSM_IDLE : FSM_EXEC;
			default:  state_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ram_re    = 1'b0;
		commit    = 1'b0;
		case (state_q)
			FSM_IDLE: req.ready = 1'b1;
			FSM_CALC: ram_re    = 1'b1;
			FSM_EXEC: commit    = out_free;
			default:  ;
		endcase
	end
endmodule
